/* hdl/rrp_pkg.sv */
// ----------------------------------------------------------------------------
// Ranging result processor package
// Shared types, status codes and constants for the ranging result pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rrp_pkg;

  typedef enum logic [3:0] {
    ST_NONE          = 4'd0,
    ST_HW_FAIL       = 4'd1,
    ST_MIN_RANGE     = 4'd2,
    ST_SYNC          = 4'd3,
    ST_BOUNDS        = 4'd4,
    ST_SIGNAL        = 4'd5,
    ST_WRAP          = 4'd6,
    ST_XTALK         = 4'd7,
    ST_CLIPPED       = 4'd8,
    ST_NO_WRAP_CHECK = 4'd9,
    ST_VALID         = 4'd10
  } status_e;

  localparam logic [7:0] RAW_HW_A      = 8'd1;
  localparam logic [7:0] RAW_HW_B      = 8'd2;
  localparam logic [7:0] RAW_HW_C      = 8'd3;
  localparam logic [7:0] RAW_SIGNAL_A  = 8'd4;
  localparam logic [7:0] RAW_BOUNDS    = 8'd5;
  localparam logic [7:0] RAW_SIGNAL_B  = 8'd6;
  localparam logic [7:0] RAW_WRAP      = 8'd7;
  localparam logic [7:0] RAW_CLIPPED   = 8'd8;
  localparam logic [7:0] RAW_VALID     = 8'd9;
  localparam logic [7:0] RAW_XTALK     = 8'd12;
  localparam logic [7:0] RAW_MIN_RANGE = 8'd13;
  localparam logic [7:0] RAW_HW_D      = 8'd17;
  localparam logic [7:0] RAW_SYNC      = 8'd18;

  localparam logic [10:0] RANGE_SCALE       = 11'd2011;
  localparam logic [10:0] RANGE_ROUND       = 11'h400;
  localparam logic [15:0] SPAD_DEFAULT      = 16'h8000;
  localparam logic [15:0] SAT16             = 16'hFFFF;
  localparam logic [15:0] TARGET_RATE_RESET = 16'd2592;

  typedef struct packed {
    logic [15:0] scaled_range;
    status_e     status;
    logic [15:0] total;
    logic [15:0] spads;
    logic        spad_zero;
  } front_t;

  typedef struct packed {
    logic [15:0] scaled_range;
    status_e     status;
    logic        spad_zero;
  } side1_t;

  typedef struct packed {
    logic [15:0] scaled_range;
    status_e     status;
    logic        dflt;
    logic        sat;
  } side2_t;

  typedef struct packed {
    logic [15:0] scaled_range;
    status_e     status;
    logic [15:0] spad_select;
  } res_t;

  function automatic status_e map_status(input logic [7:0] raw, input logic [7:0] stream);
    status_e st;
    case (raw)
      RAW_HW_A, RAW_HW_B, RAW_HW_C, RAW_HW_D: st = ST_HW_FAIL;
      RAW_MIN_RANGE:                          st = ST_MIN_RANGE;
      RAW_SYNC:                               st = ST_SYNC;
      RAW_BOUNDS:                             st = ST_BOUNDS;
      RAW_SIGNAL_A, RAW_SIGNAL_B:             st = ST_SIGNAL;
      RAW_WRAP:                               st = ST_WRAP;
      RAW_XTALK:                              st = ST_XTALK;
      RAW_CLIPPED:                            st = ST_CLIPPED;
      RAW_VALID:  st = (stream == 8'd0) ? ST_NO_WRAP_CHECK : ST_VALID;
      default:                                st = ST_NONE;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

/* hdl/ranging_result_processor.sv */
// ----------------------------------------------------------------------------
// Ranging result processor
// Turns one raw time-of-flight result record into a scaled range, a dense
// status code and the SPAD count to request for the next measurement.
//
// Input channel: in_valid_i with the six record fields; a transfer happens on
// a rising edge with in_valid_i high and in_stall_o low. Output channel:
// out_valid_o with scaled_range_o, status_code_o and spad_select_o; a
// transfer happens with out_valid_o high and out_stall_i low. One result per
// record.
// From input transfer to out_valid_o a record passes one front stage, a
// 32-stage divider for rate per SPAD, one flag stage, a 16-stage divider
// for the SPAD request, and the output register. The dividers resolve one
// bit per stage, for one record per cycle while in_stall_o is low.
// When the receiver stalls, the output register holds its result and a skid
// register catches the next one; in_stall_o then rises and the whole
// pipeline holds until the skid register drains. The user must write target_rate
// over cfg_valid_i/cfg_ready_o only while no record is in flight; the block
// does not enforce it. Reset empties the pipeline and sets target_rate to 2592.
// ----------------------------------------------------------------------------
`default_nettype none

module ranging_result_processor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_target_rate_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  raw_status_i,
  input  wire logic [7:0]  stream_seq_i,
  input  wire logic [15:0] effective_spads_i,
  input  wire logic [15:0] ambient_rate_i,
  input  wire logic [15:0] peak_rate_i,
  input  wire logic [15:0] raw_range_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      scaled_range_o,
  output logic [3:0]       status_code_o,
  output logic [15:0]      spad_select_o
);
  import rrp_pkg::*;

  localparam int Side1W = $bits(side1_t);
  localparam int Side2W = $bits(side2_t);

  logic [15:0] target_q;

  logic        pipe_adv;
  logic        f_valid;
  front_t      f_data;
  side1_t      f_side;

  logic              d1_valid;
  logic [31:0]       d1_quo;
  logic [Side1W-1:0] d1_side_v;
  side1_t            d1_side;

  logic        mid_valid_q;
  logic [31:0] mid_den_q;
  logic [31:0] mid_rem_q;
  side2_t      mid_side_q;
  logic        per_zero;
  logic        sat;
  side2_t      mid_side_d;

  logic              d2_valid;
  logic [15:0]       d2_quo;
  logic [Side2W-1:0] d2_side_v;
  side2_t            d2_side;
  res_t              pipe_res;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_take;
  logic pipe_out;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_target_rate_i;
    end
  end

  assign pipe_adv   = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  rrp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (pipe_adv),
    .valid_i           (in_valid_i),
    .raw_status_i      (raw_status_i),
    .stream_seq_i      (stream_seq_i),
    .effective_spads_i (effective_spads_i),
    .ambient_rate_i    (ambient_rate_i),
    .peak_rate_i       (peak_rate_i),
    .raw_range_i       (raw_range_i),
    .valid_o           (f_valid),
    .data_o            (f_data)
  );

  always_comb begin
    f_side.scaled_range = f_data.scaled_range;
    f_side.status       = f_data.status;
    f_side.spad_zero    = f_data.spad_zero;
  end

  rrp_div_pipe #(
    .DenW  (16),
    .Steps (32),
    .SideW (Side1W)
  ) u_div_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (pipe_adv),
    .valid_i (f_valid),
    .rem_i   (16'd0),
    .num_i   ({f_data.total, 16'd0}),
    .den_i   (f_data.spads),
    .side_i  (f_side),
    .valid_o (d1_valid),
    .quo_o   (d1_quo),
    .side_o  (d1_side_v)
  );

  assign d1_side  = d1_side_v;
  assign per_zero = (d1_quo == 32'd0);
  // quotient reaches 2^16 exactly when target_rate >= rate per SPAD
  assign sat      = ({16'd0, target_q} >= d1_quo);

  always_comb begin
    mid_side_d.scaled_range = d1_side.scaled_range;
    mid_side_d.status       = d1_side.status;
    mid_side_d.dflt         = d1_side.spad_zero || per_zero;
    mid_side_d.sat          = sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (pipe_adv) begin
      mid_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      mid_den_q  <= d1_quo;
      mid_rem_q  <= sat ? 32'd0 : {16'd0, target_q};
      mid_side_q <= mid_side_d;
    end
  end

  rrp_div_pipe #(
    .DenW  (32),
    .Steps (16),
    .SideW (Side2W)
  ) u_div_spad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (pipe_adv),
    .valid_i (mid_valid_q),
    .rem_i   (mid_rem_q),
    .num_i   (16'd0),
    .den_i   (mid_den_q),
    .side_i  (mid_side_q),
    .valid_o (d2_valid),
    .quo_o   (d2_quo),
    .side_o  (d2_side_v)
  );

  assign d2_side = d2_side_v;

  always_comb begin
    pipe_res.scaled_range = d2_side.scaled_range;
    pipe_res.status       = d2_side.status;
    if (d2_side.dflt) begin
      pipe_res.spad_select = SPAD_DEFAULT;
    end else if (d2_side.sat) begin
      pipe_res.spad_select = SAT16;
    end else begin
      pipe_res.spad_select = d2_quo;
    end
  end

  // Output register and skid register
  assign out_take = out_valid_q && !out_stall_i;
  assign pipe_out = pipe_adv && d2_valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pipe_out) begin
      if (!out_valid_q || out_take) begin
        out_valid_d = 1'b1;
        out_d       = pipe_res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = pipe_res;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign scaled_range_o = out_q.scaled_range;
  assign status_code_o  = out_q.status;
  assign spad_select_o  = out_q.spad_select;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid register filled without a stalled output");

  a_target_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> $stable(target_q))
    else $error("target rate changed without a configuration transfer");

  a_status_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_code_o <= ST_VALID))
    else $error("status code out of range");

endmodule

`default_nettype wire

/* hdl/rrp_front.sv */
// ----------------------------------------------------------------------------
// Ranging result processor front stage
// Range scaling, status mapping and rate sum saturation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rrp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           valid_i,
  input  wire logic [7:0]     raw_status_i,
  input  wire logic [7:0]     stream_seq_i,
  input  wire logic [15:0]    effective_spads_i,
  input  wire logic [15:0]    ambient_rate_i,
  input  wire logic [15:0]    peak_rate_i,
  input  wire logic [15:0]    raw_range_i,
  output logic                valid_o,
  output rrp_pkg::front_t     data_o
);
  import rrp_pkg::*;

  logic [26:0] prod;
  logic [26:0] rounded;
  logic [16:0] rsum;
  front_t      data_d;
  front_t      data_q;
  logic        valid_q;

  assign prod    = 27'(raw_range_i) * 27'(RANGE_SCALE);
  assign rounded = prod + 27'(RANGE_ROUND);
  assign rsum    = {1'b0, peak_rate_i} + {1'b0, ambient_rate_i};

  always_comb begin
    data_d.scaled_range = rounded[26:11];
    data_d.status       = map_status(raw_status_i, stream_seq_i);
    data_d.total        = rsum[16] ? SAT16 : rsum[15:0];
    data_d.spads        = effective_spads_i;
    data_d.spad_zero    = (effective_spads_i == 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* hdl/rrp_div_pipe.sv */
// ----------------------------------------------------------------------------
// Ranging result processor pipelined divider
// Restoring division, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rrp_div_pipe #(
  parameter int DenW  = 16,
  parameter int Steps = 32,
  parameter int SideW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             valid_i,
  input  wire logic [DenW-1:0]  rem_i,
  input  wire logic [Steps-1:0] num_i,
  input  wire logic [DenW-1:0]  den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output logic [Steps-1:0]      quo_o,
  output logic [SideW-1:0]      side_o
);

  logic             vld_q  [Steps];
  logic [Steps-1:0] quo_q  [Steps];
  logic [SideW-1:0] side_q [Steps];
  logic [DenW-1:0]  rem_q  [Steps-1];
  logic [DenW-1:0]  den_q  [Steps-1];
  logic [Steps-1:0] num_q  [Steps-1];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic             vld_s;
    logic [DenW-1:0]  rem_s;
    logic [DenW-1:0]  den_s;
    logic [Steps-1:0] num_s;
    logic [Steps-1:0] quo_s;
    logic [SideW-1:0] side_s;
    logic [DenW:0]    trial;
    logic [DenW:0]    diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_s  = valid_i;
      assign rem_s  = rem_i;
      assign den_s  = den_i;
      assign num_s  = num_i;
      assign quo_s  = '0;
      assign side_s = side_i;
    end else begin : g_next
      assign vld_s  = vld_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign den_s  = den_q[k-1];
      assign num_s  = num_q[k-1];
      assign quo_s  = quo_q[k-1];
      assign side_s = side_q[k-1];
    end

    assign trial = {rem_s, num_s[Steps-1]};
    assign diff  = trial - {1'b0, den_s};
    assign ge    = (trial >= {1'b0, den_s});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        quo_q[k]  <= {quo_s[Steps-2:0], ge};
        side_q[k] <= side_s;
      end
    end

    if (k < Steps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[k] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
          den_q[k] <= den_s;
          num_q[k] <= {num_s[Steps-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign quo_o   = quo_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Ranging result processor testbench
// Drives raw sensor result records through the valid/stall input channel and
// checks every scaled range, status code and SPAD request against an
// in-bench prediction. A directed table covers the field extremes, every raw
// status code and the divider corner cases. Random phases follow, each with
// its own target rate; all but the last may have bursts of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rrp_pkg::*;

  localparam int DRAIN_CYCLES    = 64;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int DIRECTED_ROWS   = 22;

  typedef struct packed {
    logic [7:0]  raw_status;
    logic [7:0]  stream_seq;
    logic [15:0] spads;
    logic [15:0] ambient;
    logic [15:0] peak;
    logic [15:0] raw_range;
  } record_t;

  typedef struct packed {
    logic [15:0] scaled_range;
    status_e     status;
    logic [15:0] spad_select;
  } ranging_t;

  typedef struct packed {
    record_t  rec;
    logic     typed;
    ranging_t want;
  } vector_t;

  localparam ranging_t NOT_TYPED = '{16'd0, ST_NONE, 16'd0};

  logic        clk_i;
  logic        rst_ni            = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_target_rate_i = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [7:0]  raw_status_i      = '0;
  logic [7:0]  stream_seq_i      = '0;
  logic [15:0] effective_spads_i = '0;
  logic [15:0] ambient_rate_i    = '0;
  logic [15:0] peak_rate_i       = '0;
  logic [15:0] raw_range_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [15:0] scaled_range_o;
  logic [3:0]  status_code_o;
  logic [15:0] spad_select_o;

  ranging_t    pending_results [$];
  logic [15:0] target_rate_copy = TARGET_RATE_RESET;
  int          mismatches       = 0;
  int          gap_pct          = 0;
  int          stall_pct        = 0;
  int          stall_left       = 0;

  vector_t directed_vectors [DIRECTED_ROWS] = '{
    '{'{8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'd0, ST_NONE, SPAD_DEFAULT}},
    '{'{RAW_HW_A, 8'd1, 16'h0100, 16'h0000, 16'h0000, 16'hFFFF}, 1'b1,
      '{16'd64351, ST_HW_FAIL, SPAD_DEFAULT}},
    '{'{RAW_HW_B, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001}, 1'b1,
      '{16'd1, ST_HW_FAIL, SPAD_DEFAULT}},
    '{'{RAW_HW_C, 8'h80, 16'h0001, 16'hFFFF, 16'hFFFF, 16'd1000}, 1'b1,
      '{16'd982, ST_HW_FAIL, 16'h0000}},
    '{'{RAW_HW_D, 8'h7F, 16'hFFFF, 16'h0000, 16'h0001, 16'd2048}, 1'b1,
      '{16'd2011, ST_HW_FAIL, SAT16}},
    '{'{RAW_MIN_RANGE, 8'h01, 16'h0A00, 16'h0100, 16'h0800, 16'd500}, 1'b0, NOT_TYPED},
    '{'{RAW_SYNC, 8'h02, 16'h0400, 16'h0200, 16'h1000, 16'd1234}, 1'b0, NOT_TYPED},
    '{'{RAW_BOUNDS, 8'h03, 16'h1000, 16'h0080, 16'h0400, 16'd7777}, 1'b0, NOT_TYPED},
    '{'{RAW_SIGNAL_A, 8'h04, 16'h2000, 16'h0010, 16'h0020, 16'd333}, 1'b0, NOT_TYPED},
    '{'{RAW_SIGNAL_B, 8'h05, 16'h0800, 16'h0300, 16'h0300, 16'd4096}, 1'b0, NOT_TYPED},
    '{'{RAW_WRAP, 8'h06, 16'hA000, 16'h2000, 16'h2000, 16'd65000}, 1'b0, NOT_TYPED},
    '{'{RAW_XTALK, 8'h07, 16'h0180, 16'h0040, 16'h0900, 16'd12}, 1'b0, NOT_TYPED},
    '{'{RAW_CLIPPED, 8'h08, 16'h0C00, 16'h0500, 16'h0100, 16'd30000}, 1'b0, NOT_TYPED},
    '{'{RAW_VALID, 8'h00, 16'h0A00, 16'h0100, 16'h0A00, 16'd800}, 1'b0, NOT_TYPED},
    '{'{RAW_VALID, 8'hFF, 16'h0A00, 16'h0100, 16'h0A00, 16'd800}, 1'b0, NOT_TYPED},
    '{'{8'hFF, 8'hFF, 16'h0000, 16'h1234, 16'h5678, 16'h0000}, 1'b1,
      '{16'd0, ST_NONE, SPAD_DEFAULT}},
    '{'{8'd10, 8'h10, 16'h0300, 16'h0011, 16'h0022, 16'd99}, 1'b0, NOT_TYPED},
    '{'{8'd11, 8'h20, 16'h0300, 16'h0011, 16'h0022, 16'd98}, 1'b0, NOT_TYPED},
    '{'{8'd14, 8'h40, 16'h0300, 16'h0011, 16'h0022, 16'd97}, 1'b0, NOT_TYPED},
    '{'{8'd16, 8'h00, 16'h0300, 16'h0011, 16'h0022, 16'd96}, 1'b0, NOT_TYPED},
    '{'{8'd19, 8'hAA, 16'h0300, 16'h0011, 16'h0022, 16'd95}, 1'b0, NOT_TYPED},
    '{'{RAW_VALID, 8'h55, 16'h8000, 16'h0001, 16'hFFFF, 16'hAAAA}, 1'b0, NOT_TYPED}
  };

  ranging_result_processor u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_target_rate_i (cfg_target_rate_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_status_i      (raw_status_i),
    .stream_seq_i      (stream_seq_i),
    .effective_spads_i (effective_spads_i),
    .ambient_rate_i    (ambient_rate_i),
    .peak_rate_i       (peak_rate_i),
    .raw_range_i       (raw_range_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .scaled_range_o    (scaled_range_o),
    .status_code_o     (status_code_o),
    .spad_select_o     (spad_select_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic ranging_t compute_ranging(input record_t r, input logic [15:0] rate);
    ranging_t    res;
    logic [31:0] scaled;
    logic [16:0] sum;
    logic [15:0] total;
    logic [31:0] per_spad;
    logic [31:0] need;
    scaled = 32'(r.raw_range) * 32'(RANGE_SCALE) + 32'(RANGE_ROUND);
    res.scaled_range = 16'(scaled >> 11);
    case (r.raw_status)
      RAW_HW_A, RAW_HW_B, RAW_HW_C, RAW_HW_D: res.status = ST_HW_FAIL;
      RAW_MIN_RANGE:                          res.status = ST_MIN_RANGE;
      RAW_SYNC:                               res.status = ST_SYNC;
      RAW_BOUNDS:                             res.status = ST_BOUNDS;
      RAW_SIGNAL_A, RAW_SIGNAL_B:             res.status = ST_SIGNAL;
      RAW_WRAP:                               res.status = ST_WRAP;
      RAW_XTALK:                              res.status = ST_XTALK;
      RAW_CLIPPED:                            res.status = ST_CLIPPED;
      RAW_VALID: begin
        res.status = (r.stream_seq == 8'd0) ? ST_NO_WRAP_CHECK : ST_VALID;
      end
      default:                                res.status = ST_NONE;
    endcase
    res.spad_select = SPAD_DEFAULT;
    if (r.spads != 16'd0) begin
      sum      = {1'b0, r.peak} + {1'b0, r.ambient};
      total    = sum[16] ? SAT16 : sum[15:0];
      per_spad = {total, 16'h0000} / {16'h0000, r.spads};
      if (per_spad != 32'd0) begin
        need            = {rate, 16'h0000} / per_spad;
        res.spad_select = (need > 32'(SAT16)) ? SAT16 : need[15:0];
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_rate();
    logic [15:0] v;
    case ($urandom_range(7))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      2, 3:    v = 16'($urandom_range(16'h2000));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic record_t random_record();
    record_t r;
    logic [7:0] known [14] = '{RAW_HW_A, RAW_HW_B, RAW_HW_C, RAW_HW_D, RAW_MIN_RANGE,
                               RAW_SYNC, RAW_BOUNDS, RAW_SIGNAL_A, RAW_SIGNAL_B,
                               RAW_WRAP, RAW_XTALK, RAW_CLIPPED, RAW_VALID, RAW_VALID};
    r.raw_status = ($urandom_range(3) == 0) ? 8'($urandom) : known[$urandom_range(13)];
    r.stream_seq = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
    case ($urandom_range(7))
      0:       r.spads = 16'h0000;
      1:       r.spads = 16'hFFFF;
      2:       r.spads = 16'($urandom_range(1, 255));
      3, 4:    r.spads = 16'($urandom_range(16'h0100, 16'hA000));
      default: r.spads = 16'($urandom);
    endcase
    r.ambient = pick_rate();
    r.peak    = pick_rate();
    case ($urandom_range(15))
      0:       r.raw_range = 16'h0000;
      1:       r.raw_range = 16'hFFFF;
      default: r.raw_range = 16'($urandom);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic send_record(input record_t r, input logic typed, input ranging_t want);
    in_valid_i        <= 1'b1;
    raw_status_i      <= r.raw_status;
    stream_seq_i      <= r.stream_seq;
    effective_spads_i <= r.spads;
    ambient_rate_i    <= r.ambient;
    peak_rate_i       <= r.peak;
    raw_range_i       <= r.raw_range;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(typed ? want : compute_ranging(r, target_rate_copy));
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_target_rate(input logic [15:0] rate);
    cfg_valid_i       <= 1'b1;
    cfg_target_rate_i <= rate;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i      <= 1'b0;
    target_rate_copy  = rate;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(1, 16);
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end
  end

  always @(posedge clk_i) begin
    ranging_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result range %0d status %0d spad %h",
                                  scaled_range_o, status_code_o, spad_select_o));
      end else begin
        want = pending_results.pop_front();
        if (scaled_range_o !== want.scaled_range)
          report_mismatch($sformatf("scaled_range %0d, want %0d", scaled_range_o,
                                    want.scaled_range));
        if (status_code_o !== want.status)
          report_mismatch($sformatf("status_code %0d, want %0d", status_code_o, want.status));
        if (spad_select_o !== want.spad_select)
          report_mismatch($sformatf("spad_select %h, want %h", spad_select_o,
                                    want.spad_select));
      end
    end
  end

  initial begin
    logic [15:0] phase_rate;
    int          pcts [3];
    pcts = '{0, 10, 40};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 10;
    stall_pct = 10;
    foreach (directed_vectors[i])
      send_record(directed_vectors[i].rec, directed_vectors[i].typed,
                  directed_vectors[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0:       phase_rate = 16'hFFFF;
        1:       phase_rate = 16'h0000;
        2:       phase_rate = 16'h0001;
        3:       phase_rate = 16'($urandom);
        4:       phase_rate = 16'h8000;
        default: phase_rate = TARGET_RATE_RESET;
      endcase
      write_target_rate(phase_rate);
      gap_pct   = (p == PHASES - 1) ? 0 : pcts[$urandom_range(2)];
      stall_pct = (p == PHASES - 1) ? 0 : pcts[$urandom_range(2)];
      repeat (ITEMS_PER_PHASE) send_record(random_record(), 1'b0, NOT_TYPED);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("ranging_result_processor regression: pass");
    end else begin
      $display("ranging_result_processor regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ranging_result_processor regression: fail");
    $finish;
  end

endmodule
